// ----- rtl/dual_pedal_torque_request_core_defines.svh -----
// Assertion macros shared by the pedal torque request checker.
`ifndef DUAL_PEDAL_TORQUE_REQUEST_CORE_DEFINES_SVH
`define DUAL_PEDAL_TORQUE_REQUEST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define DPTR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pedal torque check failed");

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define DPTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pedal torque check failed");

`endif

// ----- rtl/dptr_pkg.sv -----
// Package with types and constants of the dual pedal torque request core.
`default_nettype none
package dptr_pkg;

  localparam int RAW_W      = 10;
  localparam int LIMIT_W    = 12;
  localparam int PROD_W     = RAW_W + LIMIT_W;
  localparam int MAP_W      = PROD_W + 1;
  localparam int TORQUE_W   = 22;
  localparam int FAULT_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // History depth must stay a power of two: the mean is a shift.
  localparam int HIST_DEPTH = 4;
  localparam int HIST_SHIFT = $clog2(HIST_DEPTH);
  localparam int SUM_W      = MAP_W + HIST_SHIFT;

  localparam int MISMATCH_LIMIT = 20;
  localparam int CNT_W          = $clog2(MISMATCH_LIMIT + 1);
  localparam int MISMATCH_TOL   = 1600;

  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [RAW_W-1:0]   CAL_LOW_RST      = RAW_W'(4);
  localparam logic [RAW_W-1:0]   CAL_HIGH_RST     = RAW_W'(1023);
  localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST = LIMIT_W'(3100);

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOW      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_HIGH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LIMIT = 2'd2;

  localparam logic [FAULT_W-1:0] FAULT_OK       = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_MISMATCH = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_ZERO_RAW = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_POST
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/dual_pedal_torque_request_core.sv -----
// Top level of the dual pedal torque request core with plausibility check.
`default_nettype none
//
//  Channel   Direction  Handshake          Payload
//  in_       input      in_valid/in_stall  in_sensor_a[9:0], in_sensor_b[9:0]
//  out_      output     out_valid/out_stall out_torque_out[21:0], out_fault_code[1:0]
//  cfg_      input      cfg_valid/cfg_ready cfg_index[1:0], cfg_data[11:0]
//
//  An item occupies the core from the idle state that accepts it, then for
//  each sensor through the multiply state and the steps of the shared
//  restoring divider (one quotient bit per cycle), to the commit state that
//  loads its result into the output register.
//  The multiplier and the divider step are the arithmetic units both mappings share.
//  Reset (rst_n low, synchronous) restores the calibration registers, clears
//  the mismatch count and the history, and empties the output register.
//  A stalled result holds the commit cycle; the next item is accepted as
//  soon as the result is loaded into the output register.
//
module dual_pedal_torque_request_core
  import dptr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [RAW_W-1:0]      in_sensor_a,
  input  wire logic [RAW_W-1:0]      in_sensor_b,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [TORQUE_W-1:0]        out_torque_out,
  output logic [FAULT_W-1:0]         out_fault_code,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Control state.
  state_t            state_r, state_nxt;
  logic              sel_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic signed [MAP_W-1:0] hist_r [HIST_DEPTH];

  // Configuration.
  logic [RAW_W-1:0]   cal_low_r, cal_high_r;
  logic [LIMIT_W-1:0] torque_limit_r;

  // Payload registers.
  logic [RAW_W-1:0]        raw_a_r, raw_b_r;
  logic [PROD_W-1:0]       quo_r;
  logic [RAW_W-1:0]        rem_r;
  logic [RAW_W-1:0]        dvs_r;
  logic                    neg_r;
  logic signed [MAP_W-1:0] ma_r;
  logic [TORQUE_W-1:0]     torque_r;
  logic [FAULT_W-1:0]      fault_r;

  // Sequencer controls.
  logic accept, ld_mul, div_step, div_last, store_a, commit, out_free;

  assign in_stall       = !rst_n || (state_r != ST_IDLE);
  assign cfg_ready      = rst_n;
  assign accept         = in_valid && !in_stall;
  assign out_free       = !out_valid_r || !out_stall;
  assign div_last       = (step_r == STEP_W'(DIV_STEPS - 1));
  assign out_valid      = out_valid_r;
  assign out_torque_out = torque_r;
  assign out_fault_code = fault_r;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_last) state_nxt = sel_r ? ST_POST : ST_MUL;
      end
      ST_POST: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ld_mul   = 1'b0;
    div_step = 1'b0;
    store_a  = 1'b0;
    commit   = 1'b0;
    case (state_r)
      ST_IDLE: ;
      ST_MUL:  ld_mul = 1'b1;
      ST_DIV: begin
        div_step = 1'b1;
        store_a  = div_last && !sel_r;
      end
      ST_POST: commit = out_free;
      default: ;
    endcase
  end

  // Multiply cycle: offset times limit as a magnitude, with the sign of the
  // offset and the span kept aside so the divide truncates toward zero.
  logic [RAW_W-1:0]  raw_sel;
  logic [RAW_W:0]    offset, span, off_abs, span_abs;
  logic [PROD_W-1:0] prod;
  logic [RAW_W-1:0]  dvs_load;

  always_comb begin
    raw_sel  = sel_r ? raw_b_r : raw_a_r;
    offset   = {1'b0, raw_sel} - {1'b0, cal_low_r};
    span     = {1'b0, cal_high_r} - {1'b0, cal_low_r};
    off_abs  = offset[RAW_W] ? ((RAW_W + 1)'(0) - offset) : offset;
    span_abs = span[RAW_W] ? ((RAW_W + 1)'(0) - span) : span;
    prod     = (span == '0) ? '0 :
               PROD_W'(off_abs[RAW_W-1:0]) * PROD_W'(torque_limit_r);
    // A zero span maps to zero: divide a zero dividend by one.
    dvs_load = (span == '0) ? RAW_W'(1) : span_abs[RAW_W-1:0];
  end

  // One restoring divider step: one quotient bit per cycle.
  logic [RAW_W:0] trial;
  logic           q_bit;

  always_comb begin
    trial = {rem_r, quo_r[PROD_W-1]};
    q_bit = (trial >= {1'b0, dvs_r});
  end

  // Signed mapped value of the sensor that the divider just finished, and
  // the second sensor's value once its quotient sits in quo_r.
  logic [PROD_W-1:0]       quo_fin;
  logic signed [MAP_W-1:0] mapped;
  logic signed [MAP_W-1:0] mapped_b;

  always_comb begin
    quo_fin  = {quo_r[PROD_W-2:0], q_bit};
    mapped   = neg_r ? (MAP_W'(0) - {1'b0, quo_fin}) : {1'b0, quo_fin};
    mapped_b = neg_r ? (MAP_W'(0) - {1'b0, quo_r}) : {1'b0, quo_r};
  end

  // Commit: mismatch count, fault, history and the filtered torque.
  logic signed [MAP_W:0]   diff, diff_abs, pair_sum, pair_adj;
  logic signed [MAP_W-1:0] avg;
  logic signed [MAP_W-1:0] hist_new [HIST_DEPTH];
  logic signed [SUM_W-1:0] hist_sum;
  logic                    any_zero;
  logic [FAULT_W-1:0]      fault_nxt;
  logic [TORQUE_W-1:0]     torque_nxt;

  always_comb begin
    diff     = {ma_r[MAP_W-1], ma_r} - {mapped_b[MAP_W-1], mapped_b};
    diff_abs = diff[MAP_W] ? ((MAP_W + 1)'(0) - diff) : diff;
    if (diff_abs < (MAP_W + 1)'(MISMATCH_TOL)) begin
      cnt_nxt = '0;
    end else if (cnt_r < CNT_W'(MISMATCH_LIMIT)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end

    if (cnt_nxt >= CNT_W'(MISMATCH_LIMIT)) begin
      fault_nxt = FAULT_MISMATCH;
    end else if ((raw_a_r == '0) || (raw_b_r == '0)) begin
      fault_nxt = FAULT_ZERO_RAW;
    end else begin
      fault_nxt = FAULT_OK;
    end

    // Halving rounds toward zero: add one to a negative sum first.
    pair_sum = {ma_r[MAP_W-1], ma_r} + {mapped_b[MAP_W-1], mapped_b};
    pair_adj = pair_sum + {{MAP_W{1'b0}}, pair_sum[MAP_W]};
    avg      = pair_adj[MAP_W:1];

    hist_new[0] = avg;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      hist_new[i] = hist_r[i-1];
    end

    any_zero = 1'b0;
    hist_sum = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (hist_new[i] == '0) any_zero = 1'b1;
      hist_sum = hist_sum + SUM_W'(hist_new[i]);
    end

    // A negative mean or any empty history slot gives zero torque.
    if (any_zero || hist_sum[SUM_W-1]) begin
      torque_nxt = '0;
    end else begin
      torque_nxt = hist_sum[HIST_SHIFT +: TORQUE_W];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sel_r          <= 1'b0;
      step_r         <= '0;
      out_valid_r    <= 1'b0;
      cnt_r          <= '0;
      cal_low_r      <= CAL_LOW_RST;
      cal_high_r     <= CAL_HIGH_RST;
      torque_limit_r <= TORQUE_LIMIT_RST;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (accept) sel_r <= 1'b0;
      else if (store_a) sel_r <= 1'b1;
      if (ld_mul) step_r <= '0;
      else if (div_step) step_r <= step_r + STEP_W'(1);
      if (commit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (commit) begin
        cnt_r <= cnt_nxt;
        for (int i = 0; i < HIST_DEPTH; i++) begin
          hist_r[i] <= hist_new[i];
        end
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CAL_LOW:      cal_low_r      <= cfg_data[RAW_W-1:0];
          CFG_CAL_HIGH:     cal_high_r     <= cfg_data[RAW_W-1:0];
          CFG_TORQUE_LIMIT: torque_limit_r <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_a_r <= in_sensor_a;
      raw_b_r <= in_sensor_b;
    end
    if (ld_mul) begin
      quo_r <= prod;
      rem_r <= '0;
      dvs_r <= dvs_load;
      neg_r <= offset[RAW_W] ^ span[RAW_W];
    end else if (div_step) begin
      quo_r <= quo_fin;
      rem_r <= q_bit ? RAW_W'(trial - {1'b0, dvs_r}) : trial[RAW_W-1:0];
    end
    if (store_a) ma_r <= mapped;
    if (commit) begin
      torque_r <= torque_nxt;
      fault_r  <= fault_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dptr_checker.sv -----
// Port-level checker of the dual pedal torque request core and its bind.
`default_nettype none
`include "dual_pedal_torque_request_core_defines.svh"
module dptr_checker
  import dptr_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [TORQUE_W-1:0] out_torque_out,
  input wire logic [FAULT_W-1:0]  out_fault_code
);

  // A result never carries the unused fault code.
  `DPTR_ASSERT_NOW(a_fault_legal, out_valid, out_fault_code != 2'd3)

  // An accepted item keeps the block busy while it is divided.
  `DPTR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `DPTR_ASSERT_NEXT(a_busy_later, in_valid && !in_stall, ##1 in_stall)

  // A stalled result stays and holds its payload.
  `DPTR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_torque_out) && $stable(out_fault_code))

endmodule

bind dual_pedal_torque_request_core dptr_checker u_dptr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_torque_out (out_torque_out),
  .out_fault_code (out_fault_code)
);
`default_nettype wire

// ----- tb/dual_pedal_torque_request_core_tb.sv -----
// Self-checking testbench of the dual pedal torque request core.
`timescale 1ns / 100ps

module dual_pedal_torque_request_core_tb;
  import dptr_pkg::*;

  // The register index past the end of the register list; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One pedal item as the sender sees it. A held item is not offered until
  // every result still due has come back.
  typedef struct {
    logic [RAW_W-1:0] sensor_a;
    logic [RAW_W-1:0] sensor_b;
    bit               hold;
  } pedal_pair_t;

  typedef struct {
    logic [TORQUE_W-1:0] torque;
    logic [FAULT_W-1:0]  fault;
  } torque_fault_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [RAW_W-1:0]      in_sensor_a = '0;
  logic [RAW_W-1:0]      in_sensor_b = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TORQUE_W-1:0]   out_torque_out;
  logic [FAULT_W-1:0]    out_fault_code;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dual_pedal_torque_request_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sensor_a    (in_sensor_a),
    .in_sensor_b    (in_sensor_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_torque_out (out_torque_out),
    .out_fault_code (out_fault_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shadow copy of the calibration registers and of the core's state. The
  // calibration changes only when a register write is accepted, and the
  // state advances once per accepted item.
  logic [RAW_W-1:0]   cal_low_q      = CAL_LOW_RST;
  logic [RAW_W-1:0]   cal_high_q     = CAL_HIGH_RST;
  logic [LIMIT_W-1:0] torque_limit_q = TORQUE_LIMIT_RST;
  int                 mismatch_run   = 0;
  longint             avg_hist [HIST_DEPTH];

  pedal_pair_t   pedal_pairs_pending [$];
  torque_fault_t torque_fault_due [$];
  pedal_pair_t   pair_on_bus;

  int unsigned items_queued     = 0;
  int unsigned items_accepted   = 0;
  int unsigned results_checked  = 0;
  int unsigned mismatch_faults  = 0;
  int unsigned zero_raw_faults  = 0;
  int unsigned cal_settings     = 1;
  int unsigned fail_count       = 0;
  int unsigned send_idle_pct    = 23;
  int unsigned recv_stall_pct   = 23;

  initial begin
    foreach (avg_hist[i]) avg_hist[i] = 0;
  end

  // Linear map of one raw reading onto 0..torque_limit over the calibration
  // span. Signed division truncates toward zero, so readings below cal_low
  // and reversed spans come out negative. A zero span maps to zero.
  function automatic longint scale_reading(logic [RAW_W-1:0] raw);
    longint span;
    longint offset;
    span   = longint'(cal_high_q) - longint'(cal_low_q);
    offset = longint'(raw) - longint'(cal_low_q);
    if (span == 0) return 0;
    return (offset * longint'(torque_limit_q)) / span;
  endfunction

  // Works out the torque request and fault code for one accepted pair and
  // advances the shadow mismatch count and average history.
  function automatic torque_fault_t predict_torque_request(logic [RAW_W-1:0] raw_a,
                                                           logic [RAW_W-1:0] raw_b);
    torque_fault_t res;
    longint        map_a;
    longint        map_b;
    longint        diff;
    longint        total;
    longint        mean;
    bit            zero_seen;
    int            i;
    map_a = scale_reading(raw_a);
    map_b = scale_reading(raw_b);
    diff  = map_a - map_b;
    if (diff < 0) diff = -diff;
    // Agreement clears the run; disagreement counts up and sticks at the limit.
    if (diff < MISMATCH_TOL) mismatch_run = 0;
    else if (mismatch_run < MISMATCH_LIMIT) mismatch_run++;
    if (mismatch_run >= MISMATCH_LIMIT) res.fault = FAULT_MISMATCH;
    else if (raw_a == 0 || raw_b == 0) res.fault = FAULT_ZERO_RAW;
    else res.fault = FAULT_OK;
    for (i = HIST_DEPTH - 1; i > 0; i--) avg_hist[i] = avg_hist[i-1];
    avg_hist[0] = (map_a + map_b) / 2;
    total     = 0;
    zero_seen = 1'b0;
    for (i = 0; i < HIST_DEPTH; i++) begin
      if (avg_hist[i] == 0) zero_seen = 1'b1;
      total += avg_hist[i];
    end
    // Any zero entry forces zero torque; a negative mean is clamped.
    mean = zero_seen ? 0 : total / HIST_DEPTH;
    if (mean < 0) mean = 0;
    res.torque = TORQUE_W'(mean);
    return res;
  endfunction

  // Sender. An item stays on the bus until the core takes it; a fresh item is
  // offered only when the bus is free, and the random idle draw or a pending
  // hold can leave the bus empty for that cycle.
  always @(posedge clk) begin : item_driver
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        torque_fault_due.push_back(predict_torque_request(pair_on_bus.sensor_a,
                                                          pair_on_bus.sensor_b));
        items_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        offer = 1'b0;
        if (pedal_pairs_pending.size() > 0 && $urandom_range(99) >= send_idle_pct &&
            !(pedal_pairs_pending[0].hold && torque_fault_due.size() > 0)) begin
          pair_on_bus = pedal_pairs_pending.pop_front();
          in_sensor_a <= pair_on_bus.sensor_a;
          in_sensor_b <= pair_on_bus.sensor_b;
          offer = 1'b1;
        end
        in_valid <= offer;
      end
    end
  end

  // Receiver. Every accepted result is matched against the oldest prediction;
  // the stall line is redrawn each cycle.
  always @(posedge clk) begin : result_monitor
    torque_fault_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (torque_fault_due.size() == 0) begin
          $error("result with nothing due: torque_out %0d fault_code %0d",
                 out_torque_out, out_fault_code);
          fail_count++;
        end else begin
          due = torque_fault_due.pop_front();
          results_checked++;
          if (due.fault == FAULT_MISMATCH) mismatch_faults++;
          if (due.fault == FAULT_ZERO_RAW) zero_raw_faults++;
          if (out_torque_out !== due.torque) begin
            $error("torque_out: expected %0d, actual %0d", due.torque, out_torque_out);
            fail_count++;
          end
          if (out_fault_code !== due.fault) begin
            $error("fault_code: expected %0d, actual %0d", due.fault, out_fault_code);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_pair(logic [RAW_W-1:0] raw_a, logic [RAW_W-1:0] raw_b, bit hold);
    pedal_pair_t p;
    p.sensor_a = raw_a;
    p.sensor_b = raw_b;
    p.hold     = hold;
    pedal_pairs_pending.push_back(p);
    items_queued++;
  endtask

  // Register writes happen only while the core is idle, so the shadow copy is
  // updated at the accepting edge.
  task automatic write_cal_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CAL_LOW:      cal_low_q      = val[RAW_W-1:0];
      CFG_CAL_HIGH:     cal_high_q     = val[RAW_W-1:0];
      CFG_TORQUE_LIMIT: torque_limit_q = val[LIMIT_W-1:0];
      default:          ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic load_calibration(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                                  logic [CFG_DATA_W-1:0] lim);
    write_cal_reg(CFG_CAL_LOW, lo);
    write_cal_reg(CFG_CAL_HIGH, hi);
    write_cal_reg(CFG_TORQUE_LIMIT, lim);
    cal_settings++;
  endtask

  // Blocks until every queued item has been taken and every result is back.
  task automatic wait_for_drain();
    while (items_accepted != items_queued || torque_fault_due.size() != 0) @(posedge clk);
  endtask

  // Random traffic comes in bursts: runs of agreeing readings, long runs of
  // disagreeing readings that push the mismatch count to its limit, short runs
  // with a zero reading, and plain noise. Now and then an item is held back
  // until the core has drained.
  task automatic queue_burst();
    int               kind;
    int               len;
    int               k;
    logic [RAW_W-1:0] ra;
    logic [RAW_W-1:0] rb;
    bit               swap;
    kind = $urandom_range(9);
    if (kind <= 3) len = $urandom_range(12, 1);
    else if (kind <= 5) len = $urandom_range(26, 18);
    else if (kind == 6) len = $urandom_range(3, 1);
    else len = $urandom_range(6, 1);
    for (k = 0; k < len; k++) begin
      if (kind <= 3) begin
        ra = RAW_W'($urandom_range(1023));
        rb = ra ^ RAW_W'($urandom_range(7));
      end else if (kind <= 5) begin
        ra = RAW_W'($urandom_range(250));
        rb = RAW_W'($urandom_range(1023, 780));
      end else if (kind == 6) begin
        ra = $urandom_range(3) == 0 ? '0 : RAW_W'($urandom_range(1023));
        rb = '0;
      end else begin
        ra = RAW_W'($urandom_range(1023));
        rb = RAW_W'($urandom_range(1023));
      end
      swap = 1'($urandom_range(1));
      if (swap) queue_pair(rb, ra, $urandom_range(59) == 0);
      else queue_pair(ra, rb, $urandom_range(59) == 0);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_target;
    int unsigned phase_start;
    int          ph;
    int          lo;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset calibration: both readings zero, full
    // scale, one reading zero, readings at and just above cal_low, readings
    // below cal_low that map negative, and alternating bit patterns.
    queue_pair(10'd0, 10'd0, 1'b0);
    queue_pair(10'd1023, 10'd1023, 1'b0);
    queue_pair(10'd1023, 10'd0, 1'b0);
    queue_pair(10'd0, 10'd1023, 1'b1);
    queue_pair(10'd4, 10'd4, 1'b0);
    queue_pair(10'd5, 10'd5, 1'b0);
    queue_pair(10'd512, 10'd512, 1'b0);
    queue_pair(10'd700, 10'd690, 1'b0);
    queue_pair(10'h2AA, 10'h155, 1'b0);
    queue_pair(10'h155, 10'h2AA, 1'b0);
    queue_pair(10'd1, 10'd2, 1'b0);
    queue_pair(10'd2, 10'd1, 1'b0);
    wait_for_drain();

    // Zero calibration span: every reading maps to zero.
    load_calibration(12'd500, 12'd500, 12'd3100);
    queue_pair(10'd500, 10'd500, 1'b0);
    queue_pair(10'd0, 10'd1023, 1'b0);
    queue_pair(10'd1023, 10'd1, 1'b0);
    wait_for_drain();

    // Reversed span with the largest torque limit: high readings map negative
    // and drive the history mean below zero. A write to the unused index must
    // change nothing.
    write_cal_reg(CFG_UNUSED, 12'hABC);
    load_calibration(12'd1000, 12'd10, 12'd4095);
    queue_pair(10'd1023, 10'd1023, 1'b0);
    queue_pair(10'd1023, 10'd1020, 1'b0);
    queue_pair(10'd1023, 10'd1023, 1'b0);
    queue_pair(10'd1010, 10'd1023, 1'b0);
    queue_pair(10'd10, 10'd10, 1'b0);
    wait_for_drain();

    // Random phases, each under its own calibration. Phase 2 runs with no
    // idling on either side; the last one uses a zero torque limit.
    for (ph = 0; ph < 7; ph++) begin
      send_idle_pct  = (ph == 2) ? 0 : 23;
      recv_stall_pct = (ph == 2) ? 0 : 23;
      case (ph)
        0: begin
          load_calibration(12'd0, 12'd1023, 12'd4095);
          phase_target = 80;
        end
        1: begin
          load_calibration(12'd1023, 12'd0, 12'd2048);
          phase_target = 80;
        end
        2: begin
          load_calibration(CFG_DATA_W'(CAL_LOW_RST), CFG_DATA_W'(CAL_HIGH_RST),
                           CFG_DATA_W'(TORQUE_LIMIT_RST));
          phase_target = 90;
        end
        3: begin
          // A one-count span gives the largest mapped magnitudes.
          lo = $urandom_range(600, 400);
          load_calibration(CFG_DATA_W'(lo), CFG_DATA_W'(lo + 1),
                           CFG_DATA_W'($urandom_range(4095)));
          phase_target = 70;
        end
        4: begin
          load_calibration(CFG_DATA_W'($urandom_range(300)),
                           CFG_DATA_W'($urandom_range(1023, 700)),
                           CFG_DATA_W'($urandom_range(4095)));
          phase_target = 80;
        end
        5: begin
          // Full-width data: the upper bits of the calibration writes are dropped.
          load_calibration(CFG_DATA_W'($urandom_range(4095)),
                           CFG_DATA_W'($urandom_range(4095)),
                           CFG_DATA_W'($urandom_range(4095)));
          phase_target = 80;
        end
        default: begin
          load_calibration(CFG_DATA_W'($urandom_range(300)),
                           CFG_DATA_W'($urandom_range(1023, 700)), 12'd0);
          phase_target = 30;
        end
      endcase
      phase_start = items_queued;
      while (items_queued - phase_start < phase_target) queue_burst();
      wait_for_drain();
    end

    // Let the core sit idle long enough for a stray result to show up.
    repeat (64) @(posedge clk);
    $display("Checked %0d results from %0d pedal items over %0d calibration settings.",
             results_checked, items_accepted, cal_settings);
    $display("Expected faults seen: %0d persistent mismatch, %0d zero reading.",
             mismatch_faults, zero_raw_faults);
    if (fail_count == 0) begin
      $display("dual_pedal_torque_request_core_tb passed");
    end else begin
      $display("dual_pedal_torque_request_core_tb failed");
    end
    $finish;
  end

  // Watchdog: a correct run ends far sooner than this.
  initial begin : watchdog
    #10_000_000;
    $display("dual_pedal_torque_request_core_tb failed");
    $finish;
  end

endmodule
